@@ src/cbe_pkg.sv @@
// Shared constants for the cubic Bezier evaluator.
`default_nettype none
package cbe_pkg;

   // register stages from input to output word
   localparam int unsigned PIPE_DEPTH = 7;

   // stage valid flags, index 0 at the input side
   typedef logic [PIPE_DEPTH-1:0] stage_flags_type;

endpackage
`default_nettype wire

@@ src/cubic_bezier_evaluator_top.sv @@
// Cubic Bezier evaluator: seven-stage de Casteljau pipeline with rounding.
//
// Usage
//   Request channel req_*: four signed control values p0..p3 and the curve
//   parameter t_param (unsigned, T_FRAC_BITS fraction bits, 1.0 = 2^T_FRAC_BITS;
//   larger codes are taken as 1.0). A word is taken when req_valid is high and
//   req_stall is low.
//   Response channel rsp_*: one word per request, the curve value rounded to
//   nearest (ties upward), held steady while rsp_stall is high.
// Timing
//   One word per cycle is sustained while rsp_stall is low; each of the three
//   interpolation levels has a multiply stage and an add stage, and the final
//   add and rounding take the last stage.
// Stalls
//   Each stage advances when the stage after it is empty or moving, so bubbles
//   are squeezed out and requests are still taken while the output waits.
//   req_stall rises only once all seven stages hold a word.
// Reset
//   Synchronous, active high; clears all stage valid flags. The payload
//   registers are not reset.
`default_nettype none
module cubic_bezier_evaluator_top
   import cbe_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int T_FRAC_BITS = 15
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_p0,
   input  wire logic signed [SAMPLE_BITS-1:0] req_p1,
   input  wire logic signed [SAMPLE_BITS-1:0] req_p2,
   input  wire logic signed [SAMPLE_BITS-1:0] req_p3,
   input  wire logic        [T_FRAC_BITS:0]   req_t_param,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [SAMPLE_BITS-1:0] rsp_curve_value
);

   localparam int W1 = SAMPLE_BITS + T_FRAC_BITS;
   localparam int W2 = SAMPLE_BITS + 2 * T_FRAC_BITS;
   localparam int W3 = SAMPLE_BITS + 3 * T_FRAC_BITS;
   localparam int SH = 3 * T_FRAC_BITS;
   localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
   localparam logic signed [W3-1:0] HALF =
      {{(W3 - SH + 1){1'b0}}, {(SH - 1){1'b0}}} | (W3'(1) << (SH - 1));

   stage_flags_type    valid_ff;
   logic [PIPE_DEPTH:0] advance;

   // stage 0: inputs, t saturated, u = 1 - t
   logic signed [SAMPLE_BITS-1:0] s0_p_ff [4];
   logic        [T_FRAC_BITS:0]   s0_t_ff, s0_u_ff, s0_t_in;
   // stage 1/2: level one products and sums
   logic signed [W1-1:0]          s1_m_ff [6];
   logic signed [W1-1:0]          s1_m_in [6];
   logic signed [W1-1:0]          s2_l_ff [3];
   // stage 3/4: level two
   logic signed [W2-1:0]          s3_m_ff [4];
   logic signed [W2-1:0]          s3_m_in [4];
   logic signed [W2-1:0]          s4_l_ff [2];
   // stage 5: level three products
   logic signed [W3-1:0]          s5_m_ff [2];
   logic signed [W3-1:0]          s5_m_in [2];
   logic signed [W3-1:0]          sum3_in;
   logic        [T_FRAC_BITS:0]   t_ff [1:4];
   logic        [T_FRAC_BITS:0]   u_ff [1:4];
   logic signed [SAMPLE_BITS-1:0] rsp_curve_value_ff;

   // a stage moves when the one after it is empty or moving
   always_comb begin
      advance[PIPE_DEPTH] = !rsp_stall;
      for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   assign req_stall       = !advance[0];
   assign rsp_valid       = valid_ff[PIPE_DEPTH-1];
   assign rsp_curve_value = rsp_curve_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (advance[0]) valid_ff[0] <= req_valid;
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (advance[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign s0_t_in = (req_t_param > T_ONE) ? T_ONE : req_t_param;

   // operands widened to the product width before multiplying
   always_comb begin
      s1_m_in[0] = W1'(s0_p_ff[0]) * W1'($signed({1'b0, s0_u_ff}));
      s1_m_in[1] = W1'(s0_p_ff[1]) * W1'($signed({1'b0, s0_t_ff}));
      s1_m_in[2] = W1'(s0_p_ff[1]) * W1'($signed({1'b0, s0_u_ff}));
      s1_m_in[3] = W1'(s0_p_ff[2]) * W1'($signed({1'b0, s0_t_ff}));
      s1_m_in[4] = W1'(s0_p_ff[2]) * W1'($signed({1'b0, s0_u_ff}));
      s1_m_in[5] = W1'(s0_p_ff[3]) * W1'($signed({1'b0, s0_t_ff}));
      for (int k = 0; k < 2; k++) begin
         s3_m_in[2*k]   = W2'(s2_l_ff[k])   * W2'($signed({1'b0, u_ff[2]}));
         s3_m_in[2*k+1] = W2'(s2_l_ff[k+1]) * W2'($signed({1'b0, t_ff[2]}));
      end
      s5_m_in[0] = W3'(s4_l_ff[0]) * W3'($signed({1'b0, u_ff[4]}));
      s5_m_in[1] = W3'(s4_l_ff[1]) * W3'($signed({1'b0, t_ff[4]}));
      sum3_in    = s5_m_ff[0] + s5_m_ff[1] + HALF;
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (advance[0]) begin
         s0_p_ff[0] <= req_p0;
         s0_p_ff[1] <= req_p1;
         s0_p_ff[2] <= req_p2;
         s0_p_ff[3] <= req_p3;
         s0_t_ff    <= s0_t_in;
         s0_u_ff    <= T_ONE - s0_t_in;
      end
      if (advance[1]) begin
         s1_m_ff <= s1_m_in;
         t_ff[1] <= s0_t_ff;
         u_ff[1] <= s0_u_ff;
      end
      if (advance[2]) begin
         for (int k = 0; k < 3; k++) begin
            s2_l_ff[k] <= s1_m_ff[2*k] + s1_m_ff[2*k+1];
         end
         t_ff[2] <= t_ff[1];
         u_ff[2] <= u_ff[1];
      end
      if (advance[3]) begin
         s3_m_ff <= s3_m_in;
         t_ff[3] <= t_ff[2];
         u_ff[3] <= u_ff[2];
      end
      if (advance[4]) begin
         s4_l_ff[0] <= s3_m_ff[0] + s3_m_ff[1];
         s4_l_ff[1] <= s3_m_ff[2] + s3_m_ff[3];
         t_ff[4]    <= t_ff[3];
         u_ff[4]    <= u_ff[3];
      end
      if (advance[5]) begin
         s5_m_ff <= s5_m_in;
      end
      if (advance[6]) begin
         // arithmetic shift by 3F, keep the sample bits
         rsp_curve_value_ff <= sum3_in[W3-1:SH];
      end
   end

   // request side only stalls with every stage full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("request stalled with a bubble in the pipeline");

   // t and u weights of a live word always sum to one
   a_weights: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (s0_t_ff <= T_ONE) && (s0_u_ff == T_ONE - s0_t_ff))
      else $error("curve parameter not saturated or weights inconsistent");

   // a word waiting at the output is not overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_curve_value_ff))
      else $error("stalled output word lost");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("stage valid flags not cleared by reset");

endmodule
`default_nettype wire
